/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the prime sieve block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/core/psc_pkg.sv */
// Package of fixed widths and sequencer state codes for the prime sieve counter.
package psc_pkg;

    // Widths of the input and result fields.
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned COUNT_W = 13;

    // Sequencer states, one-hot coded.
    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_INIT    = 8'b0000_0010,
        ST_SQ_CHK  = 8'b0000_0100,
        ST_RD_WAIT = 8'b0000_1000,
        ST_STRIKE  = 8'b0001_0000,
        ST_NEXT_I  = 8'b0010_0000,
        ST_COUNT   = 8'b0100_0000,
        ST_DRAIN   = 8'b1000_0000
    } state_t;

endpackage

/* rtl/core/prime_sieve_counter.sv */
// Top level of the prime sieve counter: sequencer, shared adder and mark memory.
//
// Usage: drive limit and raise start while busy is low; that beat is taken
// at the rising edge. busy then stays high until the answer is ready. The
// result beat (prime_count, out_of_range) is shown for exactly one cycle
// with done high; the receiver cannot stall it, so it must take it then.
// A limit above MAX_LIMIT, or below two, answers in the cycle after the
// beat with busy left low. Otherwise the block walks a one-bit-per-number
// mark memory with one write port and one registered read port: it sets
// the marks 0..N; for each i with i*i <= N it reads the mark of i and,
// if i is still marked, strikes out its multiples from i*i; a final
// check ends the sieve. It then counts the marks 2..N, drains and
// answers.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// done; the mark memory is not cleared, as every limit writes its marks
// before it reads them.
module prime_sieve_counter #(
    parameter int unsigned MAX_LIMIT = 65535
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [psc_pkg::LIMIT_W-1:0]    limit,
    output logic                           busy,
    output logic                           done,
    output logic [psc_pkg::COUNT_W-1:0]    prime_count,
    output logic                           out_of_range
);

`include "assert_macros.svh"

    // Address width of the mark memory, width of the walking adder and of the count.
    localparam int unsigned AW = $clog2(MAX_LIMIT + 1);
    localparam int unsigned W  = AW + 1;
    localparam int unsigned CW = psc_pkg::COUNT_W;

    psc_pkg::state_t state_reg, state_next;

    logic [AW-1:0] n_reg, n_next;
    logic [W-1:0]  walk_reg, walk_next;
    logic [W-1:0]  sq_reg, sq_next;
    logic [AW-1:0] i_reg, i_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cnt_vld_reg, cnt_vld_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_out_reg, count_out_next;
    logic          oor_reg, oor_next;

    // Mark memory: one write port and one registered read port.
    logic          mark_mem [0:MAX_LIMIT];
    logic          rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          wr_data;

    // Shared adder operands and result.
    logic [W-1:0]  op_a;
    logic [W-1:0]  op_b;
    logic [W-1:0]  sum;
    logic [W-1:0]  n_ext;
    logic          accept;

    assign accept = start && (state_reg == psc_pkg::ST_IDLE);
    assign n_ext  = {1'b0, n_reg};

    // The one adder steps the address, the multiple j and the square of i.
    always_comb
    begin
        op_a = walk_reg;
        op_b = W'(1);
        unique case (state_reg)
            psc_pkg::ST_STRIKE:
            begin
                op_b = {1'b0, i_reg};
            end
            psc_pkg::ST_NEXT_I:
            begin
                op_a = sq_reg;
                op_b = {i_reg, 1'b1};
            end
            default:
            begin
                op_b = W'(1);
            end
        endcase
        sum = op_a + op_b;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        walk_next      = walk_reg;
        sq_next        = sq_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        cnt_vld_next   = 1'b0;
        done_next      = 1'b0;
        count_out_next = count_out_reg;
        oor_next       = oor_reg;
        wr_en          = 1'b0;
        wr_data        = 1'b0;
        rd_addr        = walk_reg[AW-1:0];

        // Marks read during the counting walk come back through the read register.
        if (cnt_vld_reg && rd_data_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    priority if (limit > psc_pkg::LIMIT_W'(MAX_LIMIT))
                    begin
                        done_next      = 1'b1;
                        count_out_next = '0;
                        oor_next       = 1'b1;
                    end
                    else if (limit < psc_pkg::LIMIT_W'(2))
                    begin
                        done_next      = 1'b1;
                        count_out_next = '0;
                        oor_next       = 1'b0;
                    end
                    else
                    begin
                        n_next     = limit[AW-1:0];
                        walk_next  = '0;
                        state_next = psc_pkg::ST_INIT;
                    end
                end
            end
            psc_pkg::ST_INIT:
            begin
                // Every number from two upward starts out marked prime.
                wr_en   = 1'b1;
                wr_data = (walk_reg >= W'(2));
                walk_next = sum;
                if (walk_reg == n_ext)
                begin
                    i_next     = AW'(2);
                    sq_next    = W'(4);
                    state_next = psc_pkg::ST_SQ_CHK;
                end
            end
            psc_pkg::ST_SQ_CHK:
            begin
                rd_addr = i_reg;
                if (sq_reg > n_ext)
                begin
                    walk_next  = W'(2);
                    cnt_next   = '0;
                    state_next = psc_pkg::ST_COUNT;
                end
                else
                begin
                    state_next = psc_pkg::ST_RD_WAIT;
                end
            end
            psc_pkg::ST_RD_WAIT:
            begin
                // Only a number still marked strikes out its multiples.
                if (rd_data_reg)
                begin
                    walk_next  = sq_reg;
                    state_next = psc_pkg::ST_STRIKE;
                end
                else
                begin
                    state_next = psc_pkg::ST_NEXT_I;
                end
            end
            psc_pkg::ST_STRIKE:
            begin
                wr_en     = 1'b1;
                wr_data   = 1'b0;
                walk_next = sum;
                if (sum > n_ext)
                begin
                    state_next = psc_pkg::ST_NEXT_I;
                end
            end
            psc_pkg::ST_NEXT_I:
            begin
                // (i+1)^2 = i^2 + 2i + 1.
                sq_next    = sum;
                i_next     = i_reg + AW'(1);
                state_next = psc_pkg::ST_SQ_CHK;
            end
            psc_pkg::ST_COUNT:
            begin
                cnt_vld_next = 1'b1;
                walk_next    = sum;
                if (walk_reg == n_ext)
                begin
                    state_next = psc_pkg::ST_DRAIN;
                end
            end
            psc_pkg::ST_DRAIN:
            begin
                // The mark of the limit itself is still in the read register.
                done_next      = 1'b1;
                count_out_next = cnt_reg + CW'(rd_data_reg);
                oor_next       = 1'b0;
                state_next     = psc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psc_pkg::ST_IDLE;
            cnt_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_vld_reg <= cnt_vld_next;
            done_reg    <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        walk_reg      <= walk_next;
        sq_reg        <= sq_next;
        i_reg         <= i_next;
        cnt_reg       <= cnt_next;
        count_out_reg <= count_out_next;
        oor_reg       <= oor_next;
    end

    // Mark memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[walk_reg[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mark_mem[rd_addr];
    end

    assign busy         = (state_reg != psc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign prime_count  = count_out_reg;
    assign out_of_range = oor_reg;

    // A result beat follows either the drain step or an immediate answer.
    `ASSERT_PROP(a_done_source, clk, rst_n,
        done |-> ($past(state_reg == psc_pkg::ST_DRAIN) || $past(accept)))

    // An out-of-range answer always carries a zero count.
    `ASSERT_PROP(a_oor_zero, clk, rst_n,
        (done && out_of_range) |-> (prime_count == '0))

    // Striking never writes past the limit.
    `ASSERT_PROP(a_strike_bound, clk, rst_n,
        (state_reg == psc_pkg::ST_STRIKE) |-> (walk_reg <= n_ext))

    // A limit above the maximum is answered in the next cycle without work.
    `ASSERT_PROP(a_oor_fast, clk, rst_n,
        (accept && (limit > psc_pkg::LIMIT_W'(MAX_LIMIT)))
            |=> (done && out_of_range && !busy))

endmodule
